// File: rtl/motor_command_and_odometry_unit_assert.svh
// Assertion macros used by the checker module of the motor command unit.
`ifndef MOTOR_COMMAND_AND_ODOMETRY_UNIT_ASSERT_SVH
`define MOTOR_COMMAND_AND_ODOMETRY_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define MCOU_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define MCOU_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/mcou_pkg.sv
// Types, codes and constants of the motor command and odometry unit.
package mcou_pkg;

	// Input item opcodes
	localparam logic [1:0] OP_RX_BYTE   = 2'd0;
	localparam logic [1:0] OP_LEFT_ENC  = 2'd1;
	localparam logic [1:0] OP_RIGHT_ENC = 2'd2;
	localparam logic [1:0] OP_TICK      = 2'd3;

	// Result kinds
	localparam logic KIND_MOTOR = 1'b0;
	localparam logic KIND_TLM   = 1'b1;

	// Configuration register indexes
	localparam logic REG_RX_HEADER = 1'b0;
	localparam logic REG_TX_HEADER = 1'b1;

	localparam logic [7:0] HEADER_RESET  = 8'h41;
	localparam logic [7:0] DUTY_RESET    = 8'hFF;

	// Frame positions
	localparam logic [1:0] POS_HEADER = 2'd0;
	localparam logic [1:0] POS_DIR    = 2'd1;
	localparam logic [1:0] POS_LEFT   = 2'd2;
	localparam logic [1:0] POS_RIGHT  = 2'd3;

	// Direction codes and the pin patterns they select
	localparam logic [7:0] DIR_FORWARD  = 8'h38;
	localparam logic [7:0] DIR_BACKWARD = 8'h32;
	localparam logic [7:0] DIR_LEFT     = 8'h34;
	localparam logic [7:0] DIR_RIGHT    = 8'h36;
	localparam logic [7:0] DIR_STOP     = 8'h35;

	localparam logic [3:0] PINS_FORWARD  = 4'h6;
	localparam logic [3:0] PINS_BACKWARD = 4'h9;
	localparam logic [3:0] PINS_LEFT     = 4'h5;
	localparam logic [3:0] PINS_RIGHT    = 4'hA;
	localparam logic [3:0] PINS_STOP     = 4'h0;

	// Telemetry frame: header plus five buffered bytes
	localparam int TLM_BYTES = 6;
	localparam int TLM_BUF   = TLM_BYTES - 1;
	localparam int TLM_CW    = $clog2(TLM_BYTES);

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] drive_pins;
		logic [7:0] left_duty;
		logic [7:0] right_duty;
		logic [7:0] tx_byte;
		logic       last;
	} out_item_t;

endpackage

// File: rtl/motor_command_and_odometry_unit.sv
// Top level: command framing, drive pin decode, wheel odometry and telemetry.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  cmd     | in        | cmd_valid/ready    | mcou_pkg::in_item_t
//  res     | out       | res_valid/ready    | mcou_pkg::out_item_t
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// Command bytes and encoder pulses are taken one per cycle while cmd_ready is
// high. A frame's result shows, from the result register, in the cycle after
// its last byte is accepted. A tick puts its header in the result register,
// the rest in a five-byte drain buffer that empties one byte per cycle unless
// the result stalls; cmd_ready is low while it drains or a result stalls.
// Reset (arst_n low) clears framing, flags, counts, pins; duties go to 8'hFF.
module motor_command_and_odometry_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  mcou_pkg::in_item_t    cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output mcou_pkg::out_item_t   res,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data
);

	logic [7:0] rx_header_q, tx_header_q;
	logic [1:0] frame_pos_q, frame_pos_n;
	logic [7:0] held_dir_q, held_left_q;
	logic       left_fwd_q, right_fwd_q, left_fwd_n, right_fwd_n;
	logic [15:0] left_pos_q, right_pos_q, left_pos_n, right_pos_n;
	logic [3:0] pins_q, pins_n;
	logic [7:0] left_cmp_q, right_cmp_q, left_cmp_n, right_cmp_n;

	logic [mcou_pkg::TLM_CW-1:0] tlm_left_q;
	logic [7:0] tlm_buf_q [mcou_pkg::TLM_BUF];

	logic      res_valid_q;
	mcou_pkg::out_item_t res_q;

	logic cmd_fire, slot_free, draining, motor_res, tick_fire;
	logic [7:0] tlm_sum;

	assign slot_free = !res_valid_q || res_ready;
	assign draining  = (tlm_left_q != '0);
	assign cmd_ready = !draining && slot_free;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign tick_fire = cmd_fire && (cmd.opcode == mcou_pkg::OP_TICK);

	// Header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_header_q <= mcou_pkg::HEADER_RESET;
			tx_header_q <= mcou_pkg::HEADER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcou_pkg::REG_RX_HEADER: rx_header_q <= cfg_data;
				mcou_pkg::REG_TX_HEADER: tx_header_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state for one accepted item
	always_comb begin
		frame_pos_n = frame_pos_q;
		left_fwd_n  = left_fwd_q;
		right_fwd_n = right_fwd_q;
		left_pos_n  = left_pos_q;
		right_pos_n = right_pos_q;
		pins_n      = pins_q;
		left_cmp_n  = left_cmp_q;
		right_cmp_n = right_cmp_q;
		motor_res   = 1'b0;
		unique case (cmd.opcode)
			mcou_pkg::OP_RX_BYTE: begin
				unique case (frame_pos_q)
					mcou_pkg::POS_HEADER: begin
						if (cmd.rx_byte == rx_header_q) frame_pos_n = mcou_pkg::POS_DIR;
					end
					mcou_pkg::POS_DIR:  frame_pos_n = mcou_pkg::POS_LEFT;
					mcou_pkg::POS_LEFT: frame_pos_n = mcou_pkg::POS_RIGHT;
					default: begin
						frame_pos_n = mcou_pkg::POS_HEADER;
						left_cmp_n  = held_left_q;
						right_cmp_n = cmd.rx_byte;
						motor_res   = 1'b1;
						unique case (held_dir_q)
							mcou_pkg::DIR_FORWARD: begin
								pins_n = mcou_pkg::PINS_FORWARD;
								left_fwd_n = 1'b1; right_fwd_n = 1'b1;
							end
							mcou_pkg::DIR_BACKWARD: begin
								pins_n = mcou_pkg::PINS_BACKWARD;
								left_fwd_n = 1'b0; right_fwd_n = 1'b0;
							end
							mcou_pkg::DIR_LEFT: begin
								pins_n = mcou_pkg::PINS_LEFT;
								left_fwd_n = 1'b0; right_fwd_n = 1'b1;
							end
							mcou_pkg::DIR_RIGHT: begin
								pins_n = mcou_pkg::PINS_RIGHT;
								left_fwd_n = 1'b1; right_fwd_n = 1'b0;
							end
							mcou_pkg::DIR_STOP: pins_n = mcou_pkg::PINS_STOP;
							default: ;
						endcase
					end
				endcase
			end
			mcou_pkg::OP_LEFT_ENC:
				left_pos_n = left_fwd_q ? left_pos_q + 16'd1 : left_pos_q - 16'd1;
			mcou_pkg::OP_RIGHT_ENC:
				right_pos_n = right_fwd_q ? right_pos_q + 16'd1 : right_pos_q - 16'd1;
			default: ;
		endcase
	end

	// Control and odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= mcou_pkg::POS_HEADER;
			left_fwd_q  <= 1'b0;
			right_fwd_q <= 1'b0;
			left_pos_q  <= '0;
			right_pos_q <= '0;
			pins_q      <= '0;
			left_cmp_q  <= mcou_pkg::DUTY_RESET;
			right_cmp_q <= mcou_pkg::DUTY_RESET;
		end else if (cmd_fire) begin
			frame_pos_q <= frame_pos_n;
			left_fwd_q  <= left_fwd_n;
			right_fwd_q <= right_fwd_n;
			left_pos_q  <= left_pos_n;
			right_pos_q <= right_pos_n;
			pins_q      <= pins_n;
			left_cmp_q  <= left_cmp_n;
			right_cmp_q <= right_cmp_n;
		end
	end

	// Held frame bytes, written before the frame completes
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.opcode == mcou_pkg::OP_RX_BYTE) begin
			if (frame_pos_q == mcou_pkg::POS_DIR)  held_dir_q  <= cmd.rx_byte;
			if (frame_pos_q == mcou_pkg::POS_LEFT) held_left_q <= cmd.rx_byte;
		end
	end

	// Telemetry checksum over the four count bytes
	assign tlm_sum = right_pos_q[15:8] + right_pos_q[7:0] + left_pos_q[15:8] + left_pos_q[7:0];

	// Drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlm_left_q <= '0;
		end else if (tick_fire) begin
			tlm_left_q <= mcou_pkg::TLM_CW'(mcou_pkg::TLM_BUF);
		end else if (draining && slot_free) begin
			tlm_left_q <= tlm_left_q - 1'b1;
		end
	end

	// Drain buffer: snapshot on a tick, shift one byte per delivered item
	always_ff @(posedge clk) begin
		if (tick_fire) begin
			tlm_buf_q[0] <= right_pos_q[15:8];
			tlm_buf_q[1] <= right_pos_q[7:0];
			tlm_buf_q[2] <= left_pos_q[15:8];
			tlm_buf_q[3] <= left_pos_q[7:0];
			tlm_buf_q[4] <= tlm_sum;
		end else if (draining && slot_free) begin
			for (int i = 0; i < mcou_pkg::TLM_BUF - 1; i++) tlm_buf_q[i] <= tlm_buf_q[i+1];
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((draining && slot_free) || tick_fire || (cmd_fire && motor_res)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		priority if (draining && slot_free) begin
			res_q.kind       <= mcou_pkg::KIND_TLM;
			res_q.drive_pins <= pins_q;
			res_q.left_duty  <= left_cmp_q;
			res_q.right_duty <= right_cmp_q;
			res_q.tx_byte    <= tlm_buf_q[0];
			res_q.last       <= (tlm_left_q == mcou_pkg::TLM_CW'(1));
		end else if (tick_fire) begin
			res_q.kind       <= mcou_pkg::KIND_TLM;
			res_q.drive_pins <= pins_q;
			res_q.left_duty  <= left_cmp_q;
			res_q.right_duty <= right_cmp_q;
			res_q.tx_byte    <= tx_header_q;
			res_q.last       <= 1'b0;
		end else if (cmd_fire && motor_res) begin
			res_q.kind       <= mcou_pkg::KIND_MOTOR;
			res_q.drive_pins <= pins_n;
			res_q.left_duty  <= left_cmp_n;
			res_q.right_duty <= right_cmp_n;
			res_q.tx_byte    <= 8'd0;
			res_q.last       <= 1'b1;
		end else begin
			res_q <= res_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/mcou_checker.sv
// Port-level checker for the motor command unit, bound to the top level.
`include "motor_command_and_odometry_unit_assert.svh"

module mcou_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_ready,
	input  mcou_pkg::in_item_t    cmd,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  mcou_pkg::out_item_t   res
);

	logic tick_fire;
	assign tick_fire = cmd_valid && cmd_ready && (cmd.opcode == mcou_pkg::OP_TICK);

	// A stalled result holds its payload
	`MCOU_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "stalled result changed")

	// A tick opens a telemetry run with a non-final byte
	`MCOU_ASSERT_NEXT(a_tick_opens, clk, arst_n, tick_fire, res_valid && res.kind == mcou_pkg::KIND_TLM && !res.last, "tick did not start telemetry")

	// No item is taken as telemetry starts to drain after a tick
	`MCOU_ASSERT_NEXT(a_tick_blocks, clk, arst_n, tick_fire, !cmd_ready, "input taken during telemetry drain")

	// Motor results are single and carry no telemetry byte
	`MCOU_ASSERT_NOW(a_motor_shape, clk, arst_n, res_valid && res.kind == mcou_pkg::KIND_MOTOR, res.last && res.tx_byte == 8'd0, "malformed motor result")

endmodule

bind motor_command_and_odometry_unit mcou_checker u_mcou_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// File: bench/motor_command_and_odometry_unit_tb.sv
// Self-checking testbench for the motor command and odometry unit.
module motor_command_and_odometry_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 200;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	mcou_pkg::in_item_t   cmd = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	mcou_pkg::out_item_t  res;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = mcou_pkg::REG_RX_HEADER;
	logic [7:0]           cfg_data = '0;

	// Shadow state of the unit
	logic [1:0]  frame_pos;
	logic [7:0]  dir_code_hold;
	logic [7:0]  left_duty_hold;
	logic        left_fwd;
	logic        right_fwd;
	logic [15:0] left_count;
	logic [15:0] right_count;
	logic [3:0]  pins;
	logic [7:0]  left_duty;
	logic [7:0]  right_duty;
	logic [7:0]  rx_hdr;
	logic [7:0]  tx_hdr;

	mcou_pkg::out_item_t owed_results[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          hold_req = 0;
	bit          cmd_gaps = 1'b0;
	bit          res_stalls = 1'b0;

	motor_command_and_odometry_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Queue one result carrying the present pins and duties
	function automatic void owe_result(logic kind, logic [7:0] tx, logic last);
		mcou_pkg::out_item_t r;
		r.kind       = kind;
		r.drive_pins = pins;
		r.left_duty  = left_duty;
		r.right_duty = right_duty;
		r.tx_byte    = tx;
		r.last       = last;
		owed_results.push_back(r);
	endfunction

	// Advance the shadow state by one accepted item and queue its results
	function automatic void predict_event(mcou_pkg::in_item_t it);
		logic [7:0] rh, rl, lh, ll, sum;
		case (it.opcode)
			mcou_pkg::OP_RX_BYTE: begin
				case (frame_pos)
					mcou_pkg::POS_HEADER:
						if (it.rx_byte == rx_hdr) frame_pos = mcou_pkg::POS_DIR;
					mcou_pkg::POS_DIR: begin
						dir_code_hold = it.rx_byte;
						frame_pos = mcou_pkg::POS_LEFT;
					end
					mcou_pkg::POS_LEFT: begin
						left_duty_hold = it.rx_byte;
						frame_pos = mcou_pkg::POS_RIGHT;
					end
					default: begin
						frame_pos  = mcou_pkg::POS_HEADER;
						left_duty  = left_duty_hold;
						right_duty = it.rx_byte;
						case (dir_code_hold)
							mcou_pkg::DIR_FORWARD: begin
								pins = mcou_pkg::PINS_FORWARD; left_fwd = 1'b1; right_fwd = 1'b1;
							end
							mcou_pkg::DIR_BACKWARD: begin
								pins = mcou_pkg::PINS_BACKWARD; left_fwd = 1'b0; right_fwd = 1'b0;
							end
							mcou_pkg::DIR_LEFT: begin
								pins = mcou_pkg::PINS_LEFT; left_fwd = 1'b0; right_fwd = 1'b1;
							end
							mcou_pkg::DIR_RIGHT: begin
								pins = mcou_pkg::PINS_RIGHT; left_fwd = 1'b1; right_fwd = 1'b0;
							end
							mcou_pkg::DIR_STOP: pins = mcou_pkg::PINS_STOP;
							default: ;
						endcase
						owe_result(mcou_pkg::KIND_MOTOR, 8'h00, 1'b1);
					end
				endcase
			end
			mcou_pkg::OP_LEFT_ENC:
				left_count = left_fwd ? left_count + 16'd1 : left_count - 16'd1;
			mcou_pkg::OP_RIGHT_ENC:
				right_count = right_fwd ? right_count + 16'd1 : right_count - 16'd1;
			default: begin
				rh  = right_count[15:8];
				rl  = right_count[7:0];
				lh  = left_count[15:8];
				ll  = left_count[7:0];
				sum = rh + rl + lh + ll;
				owe_result(mcou_pkg::KIND_TLM, tx_hdr, 1'b0);
				owe_result(mcou_pkg::KIND_TLM, rh, 1'b0);
				owe_result(mcou_pkg::KIND_TLM, rl, 1'b0);
				owe_result(mcou_pkg::KIND_TLM, lh, 1'b0);
				owe_result(mcou_pkg::KIND_TLM, ll, 1'b0);
				owe_result(mcou_pkg::KIND_TLM, sum, 1'b1);
			end
		endcase
	endfunction

	// Predict on accepted items, then check accepted results
	always @(posedge clk) begin
		mcou_pkg::out_item_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				predict_event(cmd);
			if (res_valid && res_ready) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: kind=%0d pins=%h ld=%h rd=%h tx=%h last=%0d",
							res.kind, res.drive_pins, res.left_duty, res.right_duty,
							res.tx_byte, res.last);
				end else begin
					want = owed_results.pop_front();
					if (res.kind !== want.kind || res.drive_pins !== want.drive_pins ||
							res.left_duty !== want.left_duty ||
							res.right_duty !== want.right_duty ||
							res.tx_byte !== want.tx_byte || res.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch at %0t: expected kind=%0d pins=%h ld=%h rd=%h ",
								"tx=%h last=%0d, got kind=%0d pins=%h ld=%h rd=%h tx=%h last=%0d"},
								$realtime, want.kind, want.drive_pins, want.left_duty,
								want.right_duty, want.tx_byte, want.last, res.kind,
								res.drive_pins, res.left_duty, res.right_duty, res.tx_byte,
								res.last);
					end
				end
			end
		end
	end

	// Watchdog: cycles without any item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Sender gap: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Result sink with random stalls and requested long hold-offs
	initial begin : res_sink
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			n = 0;
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
			end else if (res_stalls && $urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			end
			if (n > 0) begin
				res_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// Offer one item and return at the edge that accepts it
	task automatic send_item(input logic [1:0] op, input logic [7:0] b);
		int gap;
		gap = cmd_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{opcode: op, rx_byte: b};
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input logic [7:0] code, input logic [7:0] ld, input logic [7:0] rd);
		send_item(mcou_pkg::OP_RX_BYTE, rx_hdr);
		send_item(mcou_pkg::OP_RX_BYTE, code);
		send_item(mcou_pkg::OP_RX_BYTE, ld);
		send_item(mcou_pkg::OP_RX_BYTE, rd);
	endtask

	// Stop offering and wait until every owed result has left
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mcou_pkg::REG_RX_HEADER)
			rx_hdr = val;
		else
			tx_hdr = val;
		@(posedge clk);
	endtask

	// Telemetry straight out of reset
	task automatic test_reset_values();
		send_item(mcou_pkg::OP_TICK, 8'h00);
	endtask

	// Each direction code, duty extremes, a bad frame start and count wrap downward
	task automatic test_frames_and_codes();
		send_item(mcou_pkg::OP_RX_BYTE, 8'h00);
		send_frame(mcou_pkg::DIR_BACKWARD, 8'h00, 8'hFF);
		send_item(mcou_pkg::OP_LEFT_ENC, 8'hFF);
		send_item(mcou_pkg::OP_RIGHT_ENC, 8'h00);
		send_item(mcou_pkg::OP_TICK, 8'hFF);
		send_frame(mcou_pkg::DIR_FORWARD, 8'hFF, 8'h00);
		send_frame(mcou_pkg::DIR_LEFT, 8'h12, 8'h34);
		send_frame(mcou_pkg::DIR_RIGHT, 8'hAB, 8'hCD);
		send_frame(mcou_pkg::DIR_STOP, 8'h7F, 8'h80);
		// header value reused as an unknown direction code
		send_frame(mcou_pkg::HEADER_RESET, 8'h55, 8'hAA);
	endtask

	// Header registers at their extremes, one changed in the middle of a frame
	task automatic test_header_registers();
		send_item(mcou_pkg::OP_RX_BYTE, rx_hdr);
		send_item(mcou_pkg::OP_RX_BYTE, mcou_pkg::DIR_FORWARD);
		write_reg(mcou_pkg::REG_RX_HEADER, 8'h00);
		send_item(mcou_pkg::OP_RX_BYTE, 8'hFF);
		send_item(mcou_pkg::OP_RX_BYTE, 8'h01);
		// counts wrap upward with both wheels forward
		send_item(mcou_pkg::OP_LEFT_ENC, 8'h00);
		send_item(mcou_pkg::OP_RIGHT_ENC, 8'h00);
		send_item(mcou_pkg::OP_RX_BYTE, mcou_pkg::HEADER_RESET);
		write_reg(mcou_pkg::REG_TX_HEADER, 8'hFF);
		send_item(mcou_pkg::OP_TICK, 8'h00);
		send_frame(mcou_pkg::DIR_RIGHT, 8'h00, 8'h00);
		write_reg(mcou_pkg::REG_RX_HEADER, 8'hFF);
		write_reg(mcou_pkg::REG_TX_HEADER, 8'h00);
		send_frame(mcou_pkg::DIR_BACKWARD, 8'hFF, 8'hFF);
		send_item(mcou_pkg::OP_TICK, 8'h00);
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0, 1: return mcou_pkg::DIR_FORWARD;
			2, 3: return mcou_pkg::DIR_BACKWARD;
			4: return mcou_pkg::DIR_LEFT;
			5: return mcou_pkg::DIR_RIGHT;
			6, 7: return mcou_pkg::DIR_STOP;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed frames, pulse bursts and ticks, with stray bytes and split frames
	task automatic test_random_traffic(input int n_items);
		int start, r, k;
		write_reg(mcou_pkg::REG_RX_HEADER, 8'($urandom));
		write_reg(mcou_pkg::REG_TX_HEADER, 8'($urandom));
		start = items_sent;
		while (items_sent - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_frame(pick_code(), 8'($urandom), 8'($urandom));
			end else if (r < 58) begin
				send_item(mcou_pkg::OP_RX_BYTE, 8'($urandom));
			end else if (r < 66) begin
				// frame split by an encoder pulse and, at random, a tick
				send_item(mcou_pkg::OP_RX_BYTE, rx_hdr);
				send_item(mcou_pkg::OP_RX_BYTE, pick_code());
				send_item($urandom_range(0, 1) ? mcou_pkg::OP_LEFT_ENC : mcou_pkg::OP_RIGHT_ENC,
					8'($urandom));
				if ($urandom_range(0, 1))
					send_item(mcou_pkg::OP_TICK, 8'($urandom));
				send_item(mcou_pkg::OP_RX_BYTE, 8'($urandom));
				send_item(mcou_pkg::OP_RX_BYTE, 8'($urandom));
			end else if (r < 88) begin
				k = $urandom_range(1, 8);
				repeat (k)
					send_item($urandom_range(0, 1) ? mcou_pkg::OP_LEFT_ENC : mcou_pkg::OP_RIGHT_ENC,
						8'($urandom));
			end else begin
				send_item(mcou_pkg::OP_TICK, 8'($urandom));
			end
		end
	endtask

	// Receiver holds off long enough for the unit to stall its input
	task automatic test_backpressure();
		wait_idle();
		cmd_gaps = 1'b0;
		hold_req = HOLD_CYCLES;
		repeat (4) begin
			send_item(mcou_pkg::OP_TICK, 8'h00);
			send_frame(pick_code(), 8'($urandom), 8'($urandom));
			send_item(mcou_pkg::OP_LEFT_ENC, 8'h00);
		end
	endtask

	initial begin
		frame_pos      = mcou_pkg::POS_HEADER;
		dir_code_hold  = '0;
		left_duty_hold = '0;
		left_fwd       = 1'b0;
		right_fwd      = 1'b0;
		left_count     = '0;
		right_count    = '0;
		pins           = mcou_pkg::PINS_STOP;
		left_duty      = mcou_pkg::DUTY_RESET;
		right_duty     = mcou_pkg::DUTY_RESET;
		rx_hdr         = mcou_pkg::HEADER_RESET;
		tx_hdr         = mcou_pkg::HEADER_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		res_stalls = 1'b1;
		cmd_gaps   = 1'b1;
		test_reset_values();
		test_frames_and_codes();
		test_header_registers();

		cmd_gaps = 1'b1; res_stalls = 1'b1;
		test_random_traffic(65);
		cmd_gaps = 1'b0; res_stalls = 1'b0;
		test_random_traffic(65);
		cmd_gaps = 1'b1; res_stalls = 1'b0;
		test_random_traffic(65);
		cmd_gaps = 1'b0; res_stalls = 1'b1;
		test_random_traffic(65);

		test_backpressure();

		wait_idle();
		repeat (20) @(posedge clk);
		if (owed_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
